[design/mbe_pkg.sv]
// Package with the shared types, constants and symbol ROM of the Morse bit encoder.
`timescale 1ns / 1ps

package mbe_pkg;

    localparam int CharW      = 8;
    localparam int IndexW     = 7;
    localparam int EntryW     = 12;
    localparam int NumSyms    = EntryW / 2;
    localparam int MaxBits    = 22;
    localparam int PatW       = MaxBits;
    localparam int LenW       = 5;
    localparam int QueueDepth = 2;
    localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [1:0] SymNone  = 2'd0;
    localparam logic [1:0] SymDit   = 2'd1;
    localparam logic [1:0] SymDah   = 2'd2;
    localparam logic [1:0] SymSpace = 2'd3;

    localparam logic [LenW-1:0] DitLen   = 5'd2;
    localparam logic [LenW-1:0] DahLen   = 5'd4;
    localparam logic [LenW-1:0] SpaceLen = 5'd4;
    localparam logic [LenW-1:0] GapLen   = 5'd2;

    typedef struct packed {
        logic [PatW-1:0] pattern;
        logic [LenW-1:0] len;
    } t_item;

    typedef struct packed {
        logic  valid;
        logic  full;
        t_item head;
    } t_queue_status;

    typedef struct packed {
        logic busy;
    } t_back_status;

    localparam logic [EntryW-1:0] MorseRom [128] = '{
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h003, 12'ha66, 12'h659, 12'h000, 12'h595, 12'h000, 12'h159, 12'h6a9,
        12'h1a6, 12'h9a6, 12'h000, 12'h199, 12'ha5a, 12'h956, 12'h999, 12'h196,
        12'h2aa, 12'h2a9, 12'h2a5, 12'h295, 12'h255, 12'h155, 12'h156, 12'h15a,
        12'h16a, 12'h1aa, 12'h56a, 12'h666, 12'h000, 12'h256, 12'h000, 12'h5a5,
        12'h669, 12'h009, 12'h056, 12'h066, 12'h016, 12'h001, 12'h065, 12'h01a,
        12'h055, 12'h005, 12'h0a9, 12'h026, 12'h059, 12'h00a, 12'h006, 12'h02a,
        12'h069, 12'h09a, 12'h019, 12'h015, 12'h002, 12'h025, 12'h095, 12'h029,
        12'h096, 12'h0a6, 12'h05a, 12'h1a6, 12'h000, 12'h9a6, 12'h000, 12'h9a5,
        12'h000, 12'h009, 12'h056, 12'h066, 12'h016, 12'h001, 12'h065, 12'h01a,
        12'h055, 12'h005, 12'h0a9, 12'h026, 12'h059, 12'h00a, 12'h006, 12'h02a,
        12'h069, 12'h09a, 12'h019, 12'h015, 12'h002, 12'h025, 12'h095, 12'h029,
        12'h096, 12'h0a6, 12'h05a, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
    };

endpackage

[design/mbe_if.sv]
// Valid/ready channel interfaces for the character input and the key bit output.
`timescale 1ns / 1ps

interface mbe_in_if;
    logic                       valid;
    logic                       ready;
    logic [mbe_pkg::CharW-1:0]  character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface mbe_out_if;
    logic valid;
    logic ready;
    logic key_bit;
    logic last_bit;

    modport source (output valid, output key_bit, output last_bit, input ready);
    modport sink   (input valid, input key_bit, input last_bit, output ready);
endinterface

[design/mbe_front.sv]
// Front end: ROM lookup and expansion of one character into a key bit pattern and length.
`timescale 1ns / 1ps

module mbe_front (
    input  logic [mbe_pkg::CharW-1:0] i_character,
    output mbe_pkg::t_item            o_item
);

    logic [mbe_pkg::EntryW-1:0] entry;
    logic [mbe_pkg::PatW-1:0]   pat;
    logic [mbe_pkg::LenW-1:0]   off;
    logic                       word_space;
    logic [1:0]                 sym;

    assign entry = mbe_pkg::MorseRom[i_character[mbe_pkg::IndexW-1:0]];

    always_comb begin
        pat        = '0;
        off        = '0;
        word_space = 1'b0;
        sym        = mbe_pkg::SymNone;
        for (int i = 0; i < mbe_pkg::NumSyms; i++) begin
            sym = entry[2*i +: 2];
            case (sym)
                mbe_pkg::SymDit: begin
                    pat = pat | (mbe_pkg::PatW'(2'b01) << off);
                    off = off + mbe_pkg::DitLen;
                end
                mbe_pkg::SymDah: begin
                    pat = pat | (mbe_pkg::PatW'(4'b0111) << off);
                    off = off + mbe_pkg::DahLen;
                end
                mbe_pkg::SymSpace: begin
                    off        = off + mbe_pkg::SpaceLen;
                    word_space = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if ((entry != '0) && !word_space) begin
            off = off + mbe_pkg::GapLen;
        end
    end

    assign o_item.pattern = pat;
    assign o_item.len     = (off > mbe_pkg::LenW'(mbe_pkg::MaxBits)) ?
                            mbe_pkg::LenW'(mbe_pkg::MaxBits) : off;

endmodule

[design/mbe_queue.sv]
// Short queue of expanded characters between the front end and the serializer.
`timescale 1ns / 1ps

module mbe_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mbe_pkg::t_item        i_item,
    input  logic                  i_pop,
    output mbe_pkg::t_queue_status o_status
);

    mbe_pkg::t_item              r_mem [mbe_pkg::QueueDepth];
    logic [mbe_pkg::QPtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [mbe_pkg::QPtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [mbe_pkg::QCntW-1:0]   r_count, n_count;
    logic                        do_push;
    logic                        do_pop;

    assign do_push = i_push && (r_count != mbe_pkg::QCntW'(mbe_pkg::QueueDepth));
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == mbe_pkg::QPtrW'(mbe_pkg::QueueDepth - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == mbe_pkg::QPtrW'(mbe_pkg::QueueDepth - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == mbe_pkg::QCntW'(mbe_pkg::QueueDepth));
    assign o_status.head  = r_mem[r_rd_ptr];

endmodule

[design/mbe_back.sv]
// Back end: serializes queued key bit patterns, one bit per output transaction.
`timescale 1ns / 1ps

module mbe_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mbe_pkg::t_queue_status i_queue,
    output logic                   o_pop,
    output mbe_pkg::t_back_status  o_status,
    mbe_out_if.source              o_out
);

    logic                      r_ovalid, n_ovalid;
    logic                      r_key, n_key;
    logic                      r_last, n_last;
    logic [mbe_pkg::PatW-1:0]  r_pat, n_pat;
    logic [mbe_pkg::LenW-1:0]  r_rem, n_rem;
    logic                      advance;

    assign advance = !r_ovalid || o_out.ready;

    always_comb begin
        n_ovalid = r_ovalid;
        n_key    = r_key;
        n_last   = r_last;
        n_pat    = r_pat;
        n_rem    = r_rem;
        o_pop    = 1'b0;
        if (advance) begin
            if (r_rem != '0) begin
                n_ovalid = 1'b1;
                n_key    = r_pat[0];
                n_last   = (r_rem == mbe_pkg::LenW'(1));
                n_pat    = r_pat >> 1;
                n_rem    = r_rem - 1'b1;
            end else if (i_queue.valid) begin
                o_pop    = 1'b1;
                n_ovalid = 1'b1;
                n_key    = i_queue.head.pattern[0];
                n_last   = (i_queue.head.len == mbe_pkg::LenW'(1));
                n_pat    = i_queue.head.pattern >> 1;
                n_rem    = i_queue.head.len - 1'b1;
            end else begin
                n_ovalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_rem    <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_last <= n_last;
        r_pat  <= n_pat;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.key_bit   = r_key;
    assign o_out.last_bit  = r_last;
    assign o_status.busy   = (r_rem != '0);

endmodule

[design/morse_bit_encoder.sv]
// Top level of the Morse bit encoder: front end, queue and serializer.
//
// The input channel carries one character byte per transaction; bit 7 is
// ignored and bits 6..0 select a Morse symbol entry. The output channel
// carries one key bit per transaction, and last_bit marks the final bit of
// a character. A mapped character gives its dits and dahs followed by a
// two-unit letter gap; the space character gives four zero bits and no gap;
// an unmapped character gives no output transactions at all.
// The front end expands a character in the cycle it is accepted and writes
// it into a two-entry queue. The serializer pops it once it has no bits
// left and the output can advance, and registers its first bit. It then
// delivers one bit per cycle while the receiver is ready; a character has
// at most 22 bits. When the receiver stalls, the current bit holds and the
// queue fills; the input ready drops once both queue entries are taken.
// Synchronous reset empties the queue and the serializer.
`timescale 1ns / 1ps

module morse_bit_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mbe_in_if.sink    i_in,
    mbe_out_if.source o_out
);

    mbe_pkg::t_item         front_item;
    mbe_pkg::t_queue_status queue_status;
    mbe_pkg::t_back_status  back_status;
    logic                   push;
    logic                   pop;

    mbe_front u_front (
        .i_character (i_in.character),
        .o_item      (front_item)
    );

    assign i_in.ready = !queue_status.full;
    assign push       = i_in.valid && i_in.ready && (front_item.len != '0);

    mbe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_status (queue_status)
    );

    mbe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_queue  (queue_status),
        .o_pop    (pop),
        .o_status (back_status),
        .o_out    (o_out)
    );

`ifndef NO_ASSERTIONS
    a_more_bits_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_bit) |-> back_status.busy)
        else $error("A non-final bit was shown with no bits left in the serializer.");

    a_busy_shows_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.busy |-> o_out.valid)
        else $error("The serializer holds bits but shows no output transaction.");

    a_pushed_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (front_item.len <= mbe_pkg::LenW'(mbe_pkg::MaxBits)))
        else $error("A character longer than the bit limit entered the queue.");
`endif

endmodule
